// ----- hw/rtl/eqdc_pkg.sv -----
// Shared types and codes for the equation delimiter checker.
package eqdc_pkg;

  localparam int unsigned NUM_KINDS = 10;
  localparam int unsigned OUT_LINE_W = 20;

  typedef enum logic [3:0] {
    KIND_SPUR_EQ    = 4'd0,
    KIND_EQ_IN_DLM  = 4'd1,
    KIND_SPUR_EN    = 4'd2,
    KIND_EN_IN_DLM  = 4'd3,
    KIND_DLM_OFF    = 4'd4,
    KIND_DLM_NEW    = 4'd5,
    KIND_DLM_IN_EQ  = 4'd6,
    KIND_SPAN       = 4'd7,
    KIND_UNFIN_DLM  = 4'd8,
    KIND_UNFIN_EQ   = 4'd9
  } kind_t;

  // Line prefix matcher states.
  typedef enum logic [10:0] {
    P_START = 11'b000_0000_0001,
    P_DOT   = 11'b000_0000_0010,
    P_DOTE  = 11'b000_0000_0100,
    P_D     = 11'b000_0000_1000,
    P_DE    = 11'b000_0001_0000,
    P_DEL   = 11'b000_0010_0000,
    P_DELI  = 11'b000_0100_0000,
    P_SCAN  = 11'b000_1000_0000,
    P_OWAIT = 11'b001_0000_0000,
    P_DONE  = 11'b010_0000_0000,
    P_DEAD  = 11'b100_0000_0000
  } pstate_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_EQ    = 2'd1,
    CMD_EN    = 2'd2,
    CMD_DELIM = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SET  = 2'd1,
    ACT_OFF  = 2'd2
  } act_t;

  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UP_E    = 8'h45;
  localparam logic [7:0] CH_UP_Q    = 8'h51;
  localparam logic [7:0] CH_UP_N    = 8'h4E;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_E       = 8'h65;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_O       = 8'h6F;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]            kind;
    logic [OUT_LINE_W-1:0] line_number;
    logic [OUT_LINE_W-1:0] span_first_line;
    logic [OUT_LINE_W-1:0] span_line_count;
    logic [7:0]            delimiter_byte;
    logic                  last;
  } out_item_t;

  // All findings of one request: a kind mask plus shared fields.
  typedef struct packed {
    logic [NUM_KINDS-1:0]  mask;
    logic [OUT_LINE_W-1:0] line_number;
    logic [OUT_LINE_W-1:0] span_first;
    logic [OUT_LINE_W-1:0] span_count;
    logic [7:0]            delim;
  } ev_t;

endpackage

// ----- hw/rtl/eqdc_front.sv -----
// Front end: parses each byte, tracks line and document state, builds finding records.
module eqdc_front #(
  parameter int unsigned LINE_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  eqdc_pkg::in_item_t request,
  input  logic               delim_we,
  input  logic [7:0]         delim_data,
  output logic               ev_push,
  output eqdc_pkg::ev_t      ev
);

  localparam logic [LINE_BITS-1:0] LMAX = '1;

  logic [LINE_BITS-1:0] line_cnt, line_cnt_next;
  logic [LINE_BITS-1:0] span_start, span_start_next;
  logic                 in_eq, in_eq_next;
  logic                 unbal, unbal_next;
  logic [7:0]           cur_delim, cur_delim_next;
  logic                 has, has_next;
  logic                 odd, odd_next;
  eqdc_pkg::pstate_t    pstate, pstate_next;
  eqdc_pkg::cmd_t       cmd, cmd_next;
  logic [7:0]           pend, pend_next;
  eqdc_pkg::act_t       act, act_next;
  logic                 nonempty, nonempty_next;

  always_comb begin
    logic [7:0]           b;
    logic                 eot;
    logic                 p_has, p_odd;
    eqdc_pkg::pstate_t    p_st;
    eqdc_pkg::cmd_t       p_cmd;
    logic [7:0]           p_pend;
    eqdc_pkg::act_t       p_act;
    logic                 do_line;
    logic                 e_has, e_odd;
    eqdc_pkg::cmd_t       e_cmd;
    eqdc_pkg::act_t       e_act;
    logic [7:0]           e_pend;
    logic [LINE_BITS-1:0] line;
    logic [LINE_BITS-1:0] cnt;
    logic                 n_ineq, n_unbal, n_has, n_odd;
    logic [LINE_BITS-1:0] n_span;
    logic [7:0]           n_cur;
    logic [eqdc_pkg::NUM_KINDS-1:0] mask;
    logic [31:0]          line_w, first_w, cnt_w;

    b   = request.text_byte;
    eot = request.end_of_text;

    line_cnt_next   = line_cnt;
    span_start_next = span_start;
    in_eq_next      = in_eq;
    unbal_next      = unbal;
    cur_delim_next  = cur_delim;
    has_next        = has;
    odd_next        = odd;
    pstate_next     = pstate;
    cmd_next        = cmd;
    pend_next       = pend;
    act_next        = act;
    nonempty_next   = nonempty;

    // byte parse
    p_has  = has;
    p_odd  = odd;
    p_st   = pstate;
    p_cmd  = cmd;
    p_pend = pend;
    p_act  = act;
    if (pstate != eqdc_pkg::P_DEAD) begin
      if (cur_delim != 8'd0 && b == cur_delim) begin
        p_has = 1'b1;
        p_odd = ~odd;
      end
      if (b == 8'd0) begin
        p_st = eqdc_pkg::P_DEAD;
      end else begin
        unique case (pstate)
          eqdc_pkg::P_START: begin
            if (b == eqdc_pkg::CH_DOT) p_st = eqdc_pkg::P_DOT;
            else if (b == eqdc_pkg::CH_D && in_eq) p_st = eqdc_pkg::P_D;
            else p_st = eqdc_pkg::P_DONE;
          end
          eqdc_pkg::P_DOT:
            p_st = (b == eqdc_pkg::CH_UP_E) ? eqdc_pkg::P_DOTE : eqdc_pkg::P_DONE;
          eqdc_pkg::P_DOTE: begin
            if (b == eqdc_pkg::CH_UP_Q) p_cmd = eqdc_pkg::CMD_EQ;
            else if (b == eqdc_pkg::CH_UP_N) p_cmd = eqdc_pkg::CMD_EN;
            p_st = eqdc_pkg::P_DONE;
          end
          eqdc_pkg::P_D:
            p_st = (b == eqdc_pkg::CH_E) ? eqdc_pkg::P_DE : eqdc_pkg::P_DONE;
          eqdc_pkg::P_DE:
            p_st = (b == eqdc_pkg::CH_L) ? eqdc_pkg::P_DEL : eqdc_pkg::P_DONE;
          eqdc_pkg::P_DEL:
            p_st = (b == eqdc_pkg::CH_I) ? eqdc_pkg::P_DELI : eqdc_pkg::P_DONE;
          eqdc_pkg::P_DELI: begin
            if (b == eqdc_pkg::CH_M) begin
              p_cmd = eqdc_pkg::CMD_DELIM;
              p_st  = eqdc_pkg::P_SCAN;
            end else begin
              p_st = eqdc_pkg::P_DONE;
            end
          end
          eqdc_pkg::P_SCAN: begin
            if (b != eqdc_pkg::CH_SPACE) begin
              p_pend = b;
              p_act  = eqdc_pkg::ACT_SET;
              p_st   = (b == eqdc_pkg::CH_O) ? eqdc_pkg::P_OWAIT : eqdc_pkg::P_DONE;
            end
          end
          eqdc_pkg::P_OWAIT: begin
            if (b == eqdc_pkg::CH_F) p_act = eqdc_pkg::ACT_OFF;
            p_st = eqdc_pkg::P_DONE;
          end
          default: p_st = eqdc_pkg::P_DONE;
        endcase
      end
    end

    // line end
    do_line = eot ? nonempty : (b == eqdc_pkg::CH_NEWLINE);
    e_has   = eot ? has  : p_has;
    e_odd   = eot ? odd  : p_odd;
    e_cmd   = eot ? cmd  : p_cmd;
    e_act   = eot ? act  : p_act;
    e_pend  = eot ? pend : p_pend;

    line    = (line_cnt != LMAX) ? line_cnt + LINE_BITS'(1) : line_cnt;
    n_ineq  = in_eq;
    n_unbal = unbal;
    n_span  = span_start;
    n_cur   = cur_delim;
    n_has   = e_has;
    n_odd   = e_odd;
    mask    = '0;
    cnt     = '0;
    first_w = '0;

    unique case (e_cmd)
      eqdc_pkg::CMD_EQ: begin
        if (in_eq) mask[eqdc_pkg::KIND_SPUR_EQ] = 1'b1;
        if (unbal) mask[eqdc_pkg::KIND_EQ_IN_DLM] = 1'b1;
        n_ineq = 1'b1;
      end
      eqdc_pkg::CMD_EN: begin
        if (!in_eq) mask[eqdc_pkg::KIND_SPUR_EN] = 1'b1;
        else n_ineq = 1'b0;
        if (unbal) mask[eqdc_pkg::KIND_EN_IN_DLM] = 1'b1;
        n_span = '0;
      end
      eqdc_pkg::CMD_DELIM: begin
        if (e_act == eqdc_pkg::ACT_SET) begin
          n_cur   = e_pend;
          n_has   = 1'b0;
          n_odd   = 1'b0;
          n_unbal = 1'b0;
        end else if (e_act == eqdc_pkg::ACT_OFF) begin
          n_cur = 8'd0;
        end
        if (n_cur == 8'd0) mask[eqdc_pkg::KIND_DLM_OFF] = 1'b1;
        else mask[eqdc_pkg::KIND_DLM_NEW] = 1'b1;
      end
      eqdc_pkg::CMD_NONE: ;
      default: ;
    endcase

    if (n_has && n_ineq) mask[eqdc_pkg::KIND_DLM_IN_EQ] = 1'b1;
    if (n_has) begin
      if (n_odd) n_unbal = ~n_unbal;
      if (n_span != '0) begin
        mask[eqdc_pkg::KIND_SPAN] = 1'b1;
        cnt     = line - n_span + LINE_BITS'(1);
        first_w = 32'(n_span);
      end
      n_span = n_unbal ? line : '0;
    end

    if (!do_line) begin
      mask = '0;
      line = line_cnt;
      n_ineq  = in_eq;
      n_unbal = unbal;
      n_cur   = cur_delim;
      n_span  = span_start;
    end

    if (eot) begin
      mask[eqdc_pkg::KIND_UNFIN_DLM] = n_unbal;
      mask[eqdc_pkg::KIND_UNFIN_EQ]  = n_ineq;
    end

    line_w  = 32'(line);
    cnt_w   = 32'(cnt);
    ev.mask        = mask;
    ev.line_number = line_w[eqdc_pkg::OUT_LINE_W-1:0];
    ev.span_first  = first_w[eqdc_pkg::OUT_LINE_W-1:0];
    ev.span_count  = cnt_w[eqdc_pkg::OUT_LINE_W-1:0];
    ev.delim       = n_cur;
    ev_push        = accept && (mask != '0);

    if (accept) begin
      if (eot || do_line) begin
        line_cnt_next   = eot ? '0 : line;
        span_start_next = eot ? '0 : n_span;
        in_eq_next      = eot ? 1'b0 : n_ineq;
        unbal_next      = eot ? 1'b0 : n_unbal;
        cur_delim_next  = n_cur;
        has_next        = 1'b0;
        odd_next        = 1'b0;
        pstate_next     = eqdc_pkg::P_START;
        cmd_next        = eqdc_pkg::CMD_NONE;
        pend_next       = 8'd0;
        act_next        = eqdc_pkg::ACT_NONE;
        nonempty_next   = 1'b0;
      end else begin
        has_next      = p_has;
        odd_next      = p_odd;
        pstate_next   = p_st;
        cmd_next      = p_cmd;
        pend_next     = p_pend;
        act_next      = p_act;
        nonempty_next = 1'b1;
      end
    end

    if (delim_we) cur_delim_next = delim_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cnt   <= '0;
      span_start <= '0;
      in_eq      <= 1'b0;
      unbal      <= 1'b0;
      cur_delim  <= 8'd0;
      has        <= 1'b0;
      odd        <= 1'b0;
      pstate     <= eqdc_pkg::P_START;
      cmd        <= eqdc_pkg::CMD_NONE;
      pend       <= 8'd0;
      act        <= eqdc_pkg::ACT_NONE;
      nonempty   <= 1'b0;
    end else begin
      line_cnt   <= line_cnt_next;
      span_start <= span_start_next;
      in_eq      <= in_eq_next;
      unbal      <= unbal_next;
      cur_delim  <= cur_delim_next;
      has        <= has_next;
      odd        <= odd_next;
      pstate     <= pstate_next;
      cmd        <= cmd_next;
      pend       <= pend_next;
      act        <= act_next;
      nonempty   <= nonempty_next;
    end
  end

endmodule

// ----- hw/rtl/eqdc_queue.sv -----
// Record queue between the parser front end and the finding serializer.
module eqdc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  eqdc_pkg::ev_t wr_data,
  input  logic          rd_en,
  output eqdc_pkg::ev_t rd_data,
  output logic          q_empty,
  output logic          q_full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  eqdc_pkg::ev_t   mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == CW'(DEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// ----- hw/rtl/eqdc_back.sv -----
// Back end: unpacks each queued record into findings, lowest kind first.
module eqdc_back (
  input  logic                clk,
  input  logic                rst,
  input  eqdc_pkg::ev_t       head,
  input  logic                q_empty,
  input  logic                pop,
  output logic                q_pop,
  output logic                empty,
  output eqdc_pkg::out_item_t finding
);

  logic [eqdc_pkg::NUM_KINDS-1:0] sent;
  logic [eqdc_pkg::NUM_KINDS-1:0] rem, lsb;
  logic                           last;
  logic                           take;

  assign empty = q_empty;
  assign rem   = head.mask & ~sent;
  assign lsb   = rem & (~rem + eqdc_pkg::NUM_KINDS'(1));
  assign last  = ((rem & ~lsb) == '0);
  assign take  = pop && !q_empty;
  assign q_pop = take && last;

  always_comb begin
    finding.kind = eqdc_pkg::KIND_SPUR_EQ;
    for (int i = eqdc_pkg::NUM_KINDS - 1; i >= 0; i--) begin
      if (rem[i]) finding.kind = 4'(i);
    end
    finding.line_number     = head.line_number;
    finding.span_first_line = lsb[eqdc_pkg::KIND_SPAN] ? head.span_first : '0;
    finding.span_line_count = lsb[eqdc_pkg::KIND_SPAN] ? head.span_count : '0;
    finding.delimiter_byte  = head.delim;
    finding.last            = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (take) begin
      sent <= last ? '0 : (sent | lsb);
    end
  end

  a_head_has_work: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (rem != '0))
    else $error("queued record has no finding left");

  a_one_pick: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> $onehot(lsb))
    else $error("finding select not one-hot");

  a_stay_on_record: assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> (!q_empty && sent != '0))
    else $error("record left before its last finding");

  a_span_fields: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && finding.kind != eqdc_pkg::KIND_SPAN) |->
      (finding.span_first_line == '0 && finding.span_line_count == '0))
    else $error("span fields set on non-span finding");

endmodule

// ----- hw/rtl/eqdc_top.sv -----
// Top level of the equation delimiter checker: front end, record queue, back end.
//
//  channel   | handshake     | payload
//  ----------+---------------+--------------------------------------------
//  request   | push / full   | request  (text_byte, end_of_text)
//  finding   | pop / empty   | finding  (kind, line_number, span fields,
//            |               |           delimiter_byte, last)
//  delimiter | delim_we      | delim_data (loads the delimiter in force)
//
// One request is taken per cycle while full is low; a request that ends a line
// or the text and has findings becomes one queued record holding all of them.
// Each finding is shown once its record is at the queue head; findings drain one
// per cycle while pop is high; full rises only when QUEUE_DEPTH records wait.
// Synchronous reset clears all line and document state and sets the delimiter to 0.
module eqn_delimiter_checker_top #(
  parameter int unsigned LINE_BITS   = 20,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  eqdc_pkg::in_item_t  request,
  output logic                empty,
  input  logic                pop,
  output eqdc_pkg::out_item_t finding,
  input  logic                delim_we,
  input  logic [7:0]          delim_data
);

  logic          accept;
  logic          ev_push;
  eqdc_pkg::ev_t ev;
  eqdc_pkg::ev_t head;
  logic          q_empty, q_full, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  eqdc_front #(
    .LINE_BITS (LINE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .request    (request),
    .delim_we   (delim_we),
    .delim_data (delim_data),
    .ev_push    (ev_push),
    .ev         (ev)
  );

  eqdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_push),
    .wr_data (ev),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  eqdc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .q_pop   (q_pop),
    .empty   (empty),
    .finding (finding)
  );

endmodule
